// ----- design/assert_macros.svh -----
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// trigger in one cycle implies a consequence in the next
`define ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ----- design/trd_pkg.sv -----
// types and constants of the tuple record decoder
package trd_pkg;

    localparam int MAX_COLUMNS_DEF = 16;
    localparam int QUEUE_DEPTH     = 4;

    // configuration register indexes
    localparam logic [2:0] REG_NUM_COLUMNS  = 3'd0;
    localparam logic [2:0] REG_COLUMN_TYPES = 3'd1;
    localparam logic [2:0] REG_TAG_INTEGER  = 3'd2;
    localparam logic [2:0] REG_TAG_TEXT     = 3'd3;
    localparam logic [2:0] REG_TAG_BOOLEAN  = 3'd4;

    // column type codes
    localparam logic [1:0] TYPE_INTEGER = 2'd0;
    localparam logic [1:0] TYPE_TEXT    = 2'd1;
    localparam logic [1:0] TYPE_BOOLEAN = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_INTEGER = 3'd0;
    localparam logic [2:0] KIND_LENGTH  = 3'd1;
    localparam logic [2:0] KIND_CHAR    = 3'd2;
    localparam logic [2:0] KIND_BOOLEAN = 3'd3;
    localparam logic [2:0] KIND_STATUS  = 3'd4;

    // record status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISMATCH = 3'd1;
    localparam logic [2:0] ST_BADBOOL  = 3'd2;
    localparam logic [2:0] ST_TRUNC    = 3'd3;
    localparam logic [2:0] ST_TRAILING = 3'd4;

    typedef struct packed {
        logic [4:0]  num_columns;
        logic [31:0] column_types;
        logic [7:0]  tag_integer;
        logic [7:0]  tag_text;
        logic [7:0]  tag_boolean;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  column;
        logic [31:0] payload;
        logic [2:0]  status;
        logic        last;
    } result_t;

    // up to two results produced by one item, in order
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// ----- design/tuple_record_decoder.sv -----
// top level of the tuple record decoder
//
// Input channel (in_valid / in_stall) carries one byte item of a serialized
// row: data_byte, has_byte (byte present) and record_end (item closes row).
// Output channel (out_valid / out_stall) carries one result per item moved:
// decoded integers, text lengths, text characters, booleans, and one status
// result with last set at each record end.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
// schema and tag codes; ready is always high, write only while idle.
// An accepted item is parsed in its cycle of acceptance and its results sit
// in a four-entry result queue from the next cycle on. One item per cycle
// is taken while the queue has room for two results; an item with a value
// and a record end adds two results, which drain at one per cycle while
// the receiver does not stall.
// Reset clears the parse state and queue and loads default tags 0, 1, 2.
// When the receiver stalls the head result holds and in_stall rises once
// the queue has fewer than two free entries.
module tuple_record_decoder #(
    parameter int MAX_COLUMNS = trd_pkg::MAX_COLUMNS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        record_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [3:0]  column,
    output logic [31:0] payload,
    output logic [2:0]  status,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import trd_pkg::*;

    `include "assert_macros.svh"

    cfg_t    cfg_reg;
    push_t   push;
    result_t head;
    logic    take;
    logic    full;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign take      = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_columns  <= '0;
            cfg_reg.column_types <= '0;
            cfg_reg.tag_integer  <= 8'd0;
            cfg_reg.tag_text     <= 8'd1;
            cfg_reg.tag_boolean  <= 8'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_NUM_COLUMNS:  cfg_reg.num_columns  <= cfg_data[4:0];
                REG_COLUMN_TYPES: cfg_reg.column_types <= cfg_data;
                REG_TAG_INTEGER:  cfg_reg.tag_integer  <= cfg_data[7:0];
                REG_TAG_TEXT:     cfg_reg.tag_text     <= cfg_data[7:0];
                REG_TAG_BOOLEAN:  cfg_reg.tag_boolean  <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    trd_parser #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .take       (take),
        .data_byte  (data_byte),
        .has_byte   (has_byte),
        .record_end (record_end),
        .push       (push)
    );

    trd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .push      (push),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign kind    = head.kind;
    assign column  = head.column;
    assign payload = head.payload;
    assign status  = head.status;
    assign last    = head.last;

    `ASSERT_NEXT(a_end_gives_result, take && record_end, out_valid, "record end left no result")
    `ASSERT_ALWAYS(a_status_shape, !(out_valid && last) || (kind == KIND_STATUS && payload == '0 && column == '0), "malformed status result")
    `ASSERT_ALWAYS(a_value_shape, !(out_valid && !last) || (kind != KIND_STATUS && status == ST_OK), "malformed value result")

endmodule

// ----- design/trd_parser.sv -----
// byte parser: schema check, value assembly and record status
module trd_parser #(
    parameter int MAX_COLUMNS = trd_pkg::MAX_COLUMNS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  trd_pkg::cfg_t cfg,
    input  logic          take,
    input  logic [7:0]    data_byte,
    input  logic          has_byte,
    input  logic          record_end,
    output trd_pkg::push_t push
);
    import trd_pkg::*;

    typedef enum logic [5:0] {
        PH_TAG   = 6'b000001,
        PH_INT   = 6'b000010,
        PH_LEN   = 6'b000100,
        PH_CHARS = 6'b001000,
        PH_BOOL  = 6'b010000,
        PH_ERROR = 6'b100000
    } phase_t;

    localparam logic [4:0] MAX_COLS = 5'(MAX_COLUMNS);

    phase_t      phase_reg, phase_next;
    logic [4:0]  col_reg, col_next;
    logic [1:0]  pos_reg, pos_next;
    logic [31:0] asm_reg, asm_next;
    logic [31:0] chars_reg, chars_next;
    logic [2:0]  err_reg, err_next;

    logic [4:0]  active;
    logic [1:0]  ctype;
    logic [31:0] asm_new;
    logic        val_emit;
    result_t     val_res;
    result_t     stat_res;

    assign active = (cfg.num_columns > MAX_COLS) ? MAX_COLS : cfg.num_columns;
    assign ctype  = cfg.column_types[{col_reg[3:0], 1'b0} +: 2];

    always_comb
    begin
        case (pos_reg)
            2'd0:    asm_new = asm_reg | {24'd0, data_byte};
            2'd1:    asm_new = asm_reg | {16'd0, data_byte, 8'd0};
            2'd2:    asm_new = asm_reg | {8'd0, data_byte, 16'd0};
            default: asm_new = asm_reg | {data_byte, 24'd0};
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        col_next   = col_reg;
        pos_next   = pos_reg;
        asm_next   = asm_reg;
        chars_next = chars_reg;
        err_next   = err_reg;
        val_emit   = 1'b0;
        val_res    = '0;
        stat_res   = '0;
        val_res.column = col_reg[3:0];

        if (has_byte)
        begin
            case (phase_reg)
                PH_TAG:
                begin
                    if (col_reg >= active)
                    begin
                        err_next   = ST_TRAILING;
                        phase_next = PH_ERROR;
                    end
                    else if ((ctype == TYPE_INTEGER && data_byte == cfg.tag_integer) ||
                             (ctype == TYPE_TEXT    && data_byte == cfg.tag_text)    ||
                             (ctype == TYPE_BOOLEAN && data_byte == cfg.tag_boolean))
                    begin
                        case (ctype)
                            TYPE_INTEGER: phase_next = PH_INT;
                            TYPE_TEXT:    phase_next = PH_LEN;
                            default:      phase_next = PH_BOOL;
                        endcase
                        pos_next = 2'd0;
                        asm_next = '0;
                    end
                    else
                    begin
                        err_next   = ST_MISMATCH;
                        phase_next = PH_ERROR;
                    end
                end
                PH_INT, PH_LEN:
                begin
                    asm_next = asm_new;
                    if (pos_reg != 2'd3)
                    begin
                        pos_next = pos_reg + 2'd1;
                    end
                    else
                    begin
                        val_emit        = 1'b1;
                        val_res.payload = asm_new;
                        pos_next        = 2'd0;
                        if (phase_reg == PH_INT || asm_new == '0)
                        begin
                            // value done or empty text: on to the next column
                            col_next   = col_reg + 5'd1;
                            phase_next = PH_TAG;
                            asm_next   = '0;
                        end
                        else
                        begin
                            phase_next = PH_CHARS;
                        end
                        val_res.kind = (phase_reg == PH_INT) ? KIND_INTEGER : KIND_LENGTH;
                        if (phase_reg == PH_LEN)
                        begin
                            chars_next = asm_new;
                        end
                    end
                end
                PH_CHARS:
                begin
                    val_emit        = 1'b1;
                    val_res.kind    = KIND_CHAR;
                    val_res.payload = {24'd0, data_byte};
                    chars_next      = chars_reg - 32'd1;
                    if (chars_reg == 32'd1)
                    begin
                        col_next   = col_reg + 5'd1;
                        phase_next = PH_TAG;
                        pos_next   = 2'd0;
                        asm_next   = '0;
                    end
                end
                PH_BOOL:
                begin
                    if (data_byte > 8'd1)
                    begin
                        err_next   = ST_BADBOOL;
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        val_emit        = 1'b1;
                        val_res.kind    = KIND_BOOLEAN;
                        val_res.payload = {24'd0, data_byte};
                        col_next        = col_reg + 5'd1;
                        phase_next      = PH_TAG;
                        pos_next        = 2'd0;
                        asm_next        = '0;
                    end
                end
                default:
                begin
                    // error seen: bytes dropped until record end
                end
            endcase
        end

        stat_res.kind = KIND_STATUS;
        stat_res.last = 1'b1;
        if (err_next == ST_OK && (phase_next != PH_TAG || col_next < active))
        begin
            stat_res.status = ST_TRUNC;
        end
        else
        begin
            stat_res.status = err_next;
        end

        if (record_end)
        begin
            phase_next = PH_TAG;
            col_next   = '0;
            pos_next   = '0;
            asm_next   = '0;
            chars_next = '0;
            err_next   = ST_OK;
        end
    end

    always_comb
    begin
        push.count  = 2'(val_emit) + 2'(record_end);
        push.first  = val_emit ? val_res : stat_res;
        push.second = stat_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG;
            col_reg   <= '0;
            pos_reg   <= '0;
            asm_reg   <= '0;
            chars_reg <= '0;
            err_reg   <= ST_OK;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            col_reg   <= col_next;
            pos_reg   <= pos_next;
            asm_reg   <= asm_next;
            chars_reg <= chars_next;
            err_reg   <= err_next;
        end
    end

endmodule

// ----- design/trd_queue.sv -----
// result queue: takes up to two results a cycle, hands out one while the receiver does not stall
module trd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  trd_pkg::push_t  push,
    output logic            full,
    output logic            out_valid,
    input  logic            out_stall,
    output trd_pkg::result_t head
);
    import trd_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    result_t        entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_reg, wr_next;
    logic [PW-1:0]  rd_reg, rd_next;
    logic [PW:0]    cnt_reg, cnt_next;
    logic [1:0]     n_push;
    logic           pop;

    assign n_push    = take ? push.count : 2'd0;
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign head      = entry_reg[rd_reg];
    // room for two more results, whatever the consumer does
    assign full      = (cnt_reg > (PW+1)'(QUEUE_DEPTH - 2));

    assign wr_next  = wr_reg + PW'(n_push);
    assign rd_next  = rd_reg + PW'(pop);
    assign cnt_next = cnt_reg + (PW+1)'(n_push) - (PW+1)'(pop);

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            entry_reg[wr_reg] <= push.first;
        end
        if (n_push == 2'd2)
        begin
            entry_reg[wr_reg + PW'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- tb/tb_tuple_record_decoder.sv -----
// self-checking testbench of the tuple record decoder: schema rows, broken rows, random flow control
module tb_tuple_record_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import trd_pkg::*;

    localparam int         MAX_COLUMNS    = MAX_COLUMNS_DEF;
    localparam int         CYCLE_LIMIT    = 300000;
    localparam logic [1:0] TYPE_UNMATCHED = 2'd3;

    typedef enum logic [2:0] {
        PH_TAG, PH_INT, PH_LEN, PH_CHARS, PH_BOOL, PH_ERROR
    } parse_phase_e;

    typedef enum int {
        ROW_GOOD, ROW_BAD_TAG, ROW_BAD_BOOL, ROW_SHORT, ROW_EXTRA, ROW_NOISE
    } row_shape_e;

    typedef enum logic [1:0] {
        DRAIN_FREE, DRAIN_LIGHT, DRAIN_HEAVY, DRAIN_RUNS
    } drain_mode_e;

    class record_scoreboard;
        logic [4:0]   col_count;
        logic [31:0]  col_types;
        logic [7:0]   tag_int;
        logic [7:0]   tag_txt;
        logic [7:0]   tag_bool;
        parse_phase_e phase;
        logic [4:0]   col_idx;
        logic [1:0]   byte_pos;
        logic [31:0]  assembly;
        logic [31:0]  chars_left;
        logic [2:0]   err;
        result_t      expected_q[$];
        int           n_items;
        int           n_checked;
        int           n_fail;
        int           status_seen[5];

        function new();
            col_count = '0;
            col_types = '0;
            tag_int   = 8'd0;
            tag_txt   = 8'd1;
            tag_bool  = 8'd2;
            n_items   = 0;
            n_checked = 0;
            n_fail    = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            clear_row();
        endfunction

        function void clear_row();
            phase      = PH_TAG;
            col_idx    = '0;
            byte_pos   = '0;
            assembly   = '0;
            chars_left = '0;
            err        = ST_OK;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [4:0] active_cols();
            return (col_count > 5'(MAX_COLUMNS)) ? 5'(MAX_COLUMNS) : col_count;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_NUM_COLUMNS:  col_count = val[4:0];
                REG_COLUMN_TYPES: col_types = val;
                REG_TAG_INTEGER:  tag_int   = val[7:0];
                REG_TAG_TEXT:     tag_txt   = val[7:0];
                REG_TAG_BOOLEAN:  tag_bool  = val[7:0];
                default: ;
            endcase
        endfunction

        function void push_result(logic [2:0] k, logic [3:0] col, logic [31:0] val,
                                  logic [2:0] st, logic fin);
            result_t r;
            r.kind    = k;
            r.column  = col;
            r.payload = val;
            r.status  = st;
            r.last    = fin;
            expected_q = {expected_q, r};
        endfunction

        function void next_column();
            col_idx  = col_idx + 5'd1;
            phase    = PH_TAG;
            byte_pos = '0;
            assembly = '0;
        endfunction

        function void set_error(logic [2:0] code);
            err   = code;
            phase = PH_ERROR;
        endfunction

        function void parse_byte(logic [7:0] b);
            logic [3:0] col;
            logic [1:0] ctype;
            logic [7:0] want;
            col = col_idx[3:0];
            case (phase)
                PH_TAG: begin
                    if (col_idx >= active_cols()) begin
                        set_error(ST_TRAILING);
                        return;
                    end
                    ctype = col_types[2*int'(col) +: 2];
                    case (ctype)
                        TYPE_INTEGER: want = tag_int;
                        TYPE_TEXT:    want = tag_txt;
                        TYPE_BOOLEAN: want = tag_bool;
                        default:      want = 8'h00;
                    endcase
                    if (ctype == TYPE_UNMATCHED || b != want) begin
                        set_error(ST_MISMATCH);
                        return;
                    end
                    phase    = (ctype == TYPE_INTEGER) ? PH_INT :
                               (ctype == TYPE_TEXT) ? PH_LEN : PH_BOOL;
                    byte_pos = '0;
                    assembly = '0;
                end
                PH_INT, PH_LEN: begin
                    assembly |= 32'(b) << (8*int'(byte_pos));
                    if (byte_pos != 2'd3) begin
                        byte_pos = byte_pos + 2'd1;
                    end else if (phase == PH_INT) begin
                        push_result(KIND_INTEGER, col, assembly, ST_OK, 1'b0);
                        next_column();
                    end else begin
                        push_result(KIND_LENGTH, col, assembly, ST_OK, 1'b0);
                        chars_left = assembly;
                        byte_pos   = '0;
                        if (chars_left == 0)
                            next_column();
                        else
                            phase = PH_CHARS;
                    end
                end
                PH_CHARS: begin
                    push_result(KIND_CHAR, col, 32'(b), ST_OK, 1'b0);
                    chars_left = chars_left - 32'd1;
                    if (chars_left == 0)
                        next_column();
                end
                PH_BOOL: begin
                    if (b > 8'd1) begin
                        set_error(ST_BADBOOL);
                        return;
                    end
                    push_result(KIND_BOOLEAN, col, 32'(b), ST_OK, 1'b0);
                    next_column();
                end
                default: ;
            endcase
        endfunction

        function void note_item(logic [7:0] b, logic has, logic fin);
            logic [2:0] st;
            n_items++;
            if (has)
                parse_byte(b);
            if (fin) begin
                st = err;
                if (st == ST_OK && (phase != PH_TAG || col_idx < active_cols()))
                    st = ST_TRUNC;
                push_result(KIND_STATUS, 4'd0, 32'd0, st, 1'b1);
                status_seen[int'(st)]++;
                clear_row();
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected result: kind=%0d column=%0d payload=%h status=%0d last=%0d",
                             got.kind, got.column, got.payload, got.status, got.last);
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            if (got.kind !== want.kind || got.column !== want.column ||
                got.payload !== want.payload || got.status !== want.status ||
                got.last !== want.last) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("result %0d mismatch: expected kind=%0d column=%0d payload=%h status=%0d last=%0d, got kind=%0d column=%0d payload=%h status=%0d last=%0d",
                             n_checked, want.kind, want.column, want.payload, want.status,
                             want.last, got.kind, got.column, got.payload, got.status,
                             got.last);
            end
        endfunction
    endclass

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte  = 8'd0;
    logic        has_byte   = 1'b0;
    logic        record_end = 1'b0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [2:0]  kind;
    logic [3:0]  column;
    logic [31:0] payload;
    logic [2:0]  status;
    logic        last;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index  = 3'd0;
    logic [31:0] cfg_data   = 32'd0;

    record_scoreboard sb = new();
    cfg_t             schema;
    int               burst_left  = 0;
    int               sent        = 0;
    int               cycle_count = 0;
    drain_mode_e      drain_mode  = DRAIN_FREE;
    int               drain_hold  = 0;

    tuple_record_decoder u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .has_byte   (has_byte),
        .record_end (record_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .column     (column),
        .payload    (payload),
        .status     (status),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver stall pattern, mode redrawn at random whenever its hold count runs out
    always @(posedge clk)
    begin
        if (drain_hold == 0)
        begin
            drain_mode <= drain_mode_e'($urandom_range(0, 3));
            drain_hold <= $urandom_range(20, 80);
        end
        else
        begin
            drain_hold <= drain_hold - 1;
        end
        case (drain_mode)
            DRAIN_FREE:  out_stall <= 1'b0;
            DRAIN_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
            DRAIN_HEAVY: out_stall <= ($urandom_range(0, 2) != 0);
            default:     out_stall <= drain_hold[3];
        endcase
    end

    // handshakes are settled by mid-cycle and hold until the next rising edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                sb.note_item(data_byte, has_byte, record_end);
            if (out_valid && !out_stall)
                sb.check_result({kind, column, payload, status, last});
        end
    end

    task automatic send_item(input logic [7:0] b, input logic has, input logic fin);
        bit taken;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        in_valid   <= 1'b1;
        data_byte  <= b;
        has_byte   <= has;
        record_end <= fin;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        if (has || fin)
            sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic set_schema(input cfg_t c, input bit add_unknown);
        schema = c;
        write_reg(REG_NUM_COLUMNS, 32'(c.num_columns));
        write_reg(REG_COLUMN_TYPES, c.column_types);
        write_reg(REG_TAG_INTEGER, 32'(c.tag_integer));
        write_reg(REG_TAG_TEXT, 32'(c.tag_text));
        write_reg(REG_TAG_BOOLEAN, 32'(c.tag_boolean));
        if (add_unknown)
            write_reg(REG_TAG_BOOLEAN + 3'($urandom_range(1, 3)), $urandom);
        cfg_valid <= 1'b0;
    endtask

    // wait until the block holds nothing: the last result is out, input idle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_row(input row_shape_e shape);
        logic [7:0]  row_bytes[$];
        logic [1:0]  ctype;
        logic [7:0]  tag;
        logic [31:0] value;
        int          ncols;
        int          bad_col;
        int          len;
        bit          end_on_byte;
        ncols   = (schema.num_columns > MAX_COLUMNS) ? MAX_COLUMNS : schema.num_columns;
        bad_col = (ncols > 0) ? $urandom_range(0, ncols - 1) : 0;
        if (shape == ROW_NOISE)
        begin
            repeat ($urandom_range(0, 8)) row_bytes = {row_bytes, 8'($urandom)};
        end
        else
        begin
            for (int c = 0; c < ncols; c++)
            begin
                ctype = schema.column_types[2*c +: 2];
                case (ctype)
                    TYPE_INTEGER: tag = schema.tag_integer;
                    TYPE_TEXT:    tag = schema.tag_text;
                    TYPE_BOOLEAN: tag = schema.tag_boolean;
                    default:      tag = 8'($urandom);
                endcase
                if (shape == ROW_BAD_TAG && c == bad_col)
                    tag = tag ^ 8'($urandom_range(1, 255));
                row_bytes = {row_bytes, tag};
                case (ctype)
                    TYPE_INTEGER:
                    begin
                        value = $urandom;
                        for (int k = 0; k < 4; k++) row_bytes = {row_bytes, value[8*k +: 8]};
                    end
                    TYPE_TEXT:
                    begin
                        len   = $urandom_range(0, 4);
                        value = 32'(len);
                        // huge length that the row never fills
                        if (shape == ROW_SHORT && c == bad_col && $urandom_range(0, 1) == 1)
                            value = $urandom | 32'h100;
                        for (int k = 0; k < 4; k++) row_bytes = {row_bytes, value[8*k +: 8]};
                        repeat (len) row_bytes = {row_bytes, 8'($urandom)};
                    end
                    TYPE_BOOLEAN:
                    begin
                        if (shape == ROW_BAD_BOOL && c == bad_col)
                            row_bytes = {row_bytes, 8'($urandom_range(2, 255))};
                        else
                            row_bytes = {row_bytes, 8'($urandom_range(0, 1))};
                    end
                    default: ;
                endcase
            end
            if (shape == ROW_SHORT && row_bytes.size() > 0)
                repeat ($urandom_range(1, row_bytes.size())) void'(row_bytes.pop_back());
            if (shape == ROW_EXTRA)
                repeat ($urandom_range(1, 3)) row_bytes = {row_bytes, 8'($urandom)};
        end
        end_on_byte = (row_bytes.size() > 0) && ($urandom_range(0, 1) == 1);
        foreach (row_bytes[i])
        begin
            // item with neither byte nor end, ignored by the block
            if ($urandom_range(0, 15) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(row_bytes[i], 1'b1, end_on_byte && (i == row_bytes.size() - 1));
        end
        if (!end_on_byte)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    initial
    begin
        cfg_t       c;
        int         phase_start;
        int         pick;
        row_shape_e shape;
        logic [7:0] good_row[13] = '{8'h80, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
                                     8'h41, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h80};

        schema = '{num_columns: 5'd0, column_types: 32'd0,
                   tag_integer: 8'd0, tag_text: 8'd1, tag_boolean: 8'd2};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset schema has no columns: empty row, then a byte past the end
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h5A, 1'b0, 1'b0);
        wait_idle();

        // boolean, text, integer columns with extreme tag codes
        c = '{num_columns: 5'd3, column_types: 32'h0000_0006,
              tag_integer: 8'hFF, tag_text: 8'h00, tag_boolean: 8'h80};
        set_schema(c, 1'b0);
        send_item(8'h7F, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h02, 1'b1, 1'b1);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        foreach (good_row[i])
            send_item(good_row[i], 1'b1, i == 12);

        for (int p = 0; p < 8; p++)
        begin
            wait_idle();
            c.column_types = '0;
            for (int k = 0; k < MAX_COLUMNS; k++)
            begin
                c.column_types[2*k +: 2] = 2'($urandom_range(0, 2));
                if (p > 4 && $urandom_range(0, 15) == 0)
                    c.column_types[2*k +: 2] = TYPE_UNMATCHED;
            end
            case (p)
                0:       c.num_columns = 5'd16;
                1:       c.num_columns = 5'd31;
                2:       c.num_columns = 5'd0;
                7:       c.num_columns = 5'($urandom_range(17, 30));
                default: c.num_columns = 5'($urandom_range(1, 16));
            endcase
            if (p == 3)
                c.column_types = 32'hFFFF_FFFF;
            c.tag_integer = 8'($urandom);
            c.tag_text    = 8'($urandom);
            c.tag_boolean = 8'($urandom);
            if (p == 4)
            begin
                c.tag_text    = c.tag_integer;
                c.tag_boolean = c.tag_integer;
            end
            if (p == 6)
            begin
                c.tag_integer = 8'h00;
                c.tag_text    = 8'hFF;
                c.tag_boolean = 8'h80;
            end
            set_schema(c, p == 4);
            phase_start = sent;
            while (sent - phase_start < 63)
            begin
                pick = $urandom_range(0, 19);
                if (pick <= 10)      shape = ROW_GOOD;
                else if (pick <= 12) shape = ROW_BAD_TAG;
                else if (pick <= 14) shape = ROW_BAD_BOOL;
                else if (pick <= 16) shape = ROW_SHORT;
                else if (pick <= 18) shape = ROW_EXTRA;
                else                 shape = ROW_NOISE;
                send_row(shape);
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);

        $display("covered %0d items, %0d results checked, %0d mismatches",
                 sb.n_items, sb.n_checked, sb.n_fail);
        $display("row status: %0d ok, %0d type mismatch, %0d bad boolean, %0d truncated, %0d trailing",
                 sb.status_seen[ST_OK], sb.status_seen[ST_MISMATCH], sb.status_seen[ST_BADBOOL],
                 sb.status_seen[ST_TRUNC], sb.status_seen[ST_TRAILING]);
        if (sb.n_fail == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
